// File: hw/rtl/vibration_pattern_sequencer_defines.svh
// Assertion helpers for the vibration pattern sequencer checkers.
`ifndef VIBRATION_PATTERN_SEQUENCER_DEFINES_SVH
`define VIBRATION_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define VPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vps check failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted.
`define VPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vps check failed: next-cycle implication");

// Next-cycle implication that is also checked around reset.
`define VPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("vps check failed: reset behavior");

`endif

// File: hw/rtl/vps_pkg.sv
`timescale 1ns / 1ps
package vps_pkg;

	localparam int TICK_W   = 16;
	localparam int REPS_W   = 14;
	localparam int FUNC_W   = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FAST_ON        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_SHORT_GAP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_LONG_GAP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ON        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GAP       = 3'd4;

	localparam logic [TICK_W-1:0] RST_FAST_ON        = 16'd300;
	localparam logic [TICK_W-1:0] RST_FAST_SHORT_GAP = 16'd200;
	localparam logic [TICK_W-1:0] RST_FAST_LONG_GAP  = 16'd1200;
	localparam logic [TICK_W-1:0] RST_SLOW_ON        = 16'd300;
	localparam logic [TICK_W-1:0] RST_SLOW_GAP       = 16'd1700;

	localparam logic PATTERN_FAST = 1'b0;

	typedef struct packed {
		logic [TICK_W-1:0] fast_on;
		logic [TICK_W-1:0] fast_short_gap;
		logic [TICK_W-1:0] fast_long_gap;
		logic [TICK_W-1:0] slow_on;
		logic [TICK_W-1:0] slow_gap;
	} cfg_t;

	typedef struct packed {
		logic [REPS_W-1:0] repeat_count;
		logic              pattern;
		logic [FUNC_W-1:0] func;
	} item_t;

	typedef struct packed {
		logic busy_res;
		logic motor_on;
	} result_t;

	typedef struct packed {
		logic              level;
		logic [TICK_W-1:0] ticks;
	} phase_t;

	// Level and duration of a phase; fast pattern cycles over four phases, slow over two.
	function automatic phase_t load_phase(input logic pattern, input logic [1:0] idx,
			input cfg_t cfg);
		phase_t p;
		if (pattern == PATTERN_FAST) begin
			case (idx)
				2'd0: begin p.level = 1'b1; p.ticks = cfg.fast_on; end
				2'd1: begin p.level = 1'b0; p.ticks = cfg.fast_short_gap; end
				2'd2: begin p.level = 1'b1; p.ticks = cfg.fast_on; end
				default: begin p.level = 1'b0; p.ticks = cfg.fast_long_gap; end
			endcase
		end else if (idx[0] == 1'b0) begin
			p.level = 1'b1;
			p.ticks = cfg.slow_on;
		end else begin
			p.level = 1'b0;
			p.ticks = cfg.slow_gap;
		end
		return p;
	endfunction

endpackage

// File: hw/rtl/vps_cfg.sv
`timescale 1ns / 1ps
module vps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [vps_pkg::CFG_IDX_W-1:0]  index,
	input  logic [vps_pkg::TICK_W-1:0]     data,
	output vps_pkg::cfg_t                  cfg
);
	import vps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_on        <= RST_FAST_ON;
			cfg_q.fast_short_gap <= RST_FAST_SHORT_GAP;
			cfg_q.fast_long_gap  <= RST_FAST_LONG_GAP;
			cfg_q.slow_on        <= RST_SLOW_ON;
			cfg_q.slow_gap       <= RST_SLOW_GAP;
		end else if (wr_en) begin
			case (index)
				CFG_FAST_ON:        cfg_q.fast_on        <= data;
				CFG_FAST_SHORT_GAP: cfg_q.fast_short_gap <= data;
				CFG_FAST_LONG_GAP:  cfg_q.fast_long_gap  <= data;
				CFG_SLOW_ON:        cfg_q.slow_on        <= data;
				CFG_SLOW_GAP:       cfg_q.slow_gap       <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/vps_core.sv
`timescale 1ns / 1ps
module vps_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  vps_pkg::item_t  item,
	input  vps_pkg::cfg_t   cfg,
	output vps_pkg::result_t result
);
	import vps_pkg::*;

	logic              active_q,  active_d;
	logic              pattern_q, pattern_d;
	logic [TICK_W-1:0] total_q,   total_d;
	logic [TICK_W-1:0] index_q,   index_d;
	logic [TICK_W-1:0] ticks_q,   ticks_d;
	logic              level_q,   level_d;
	phase_t            first_ph;
	phase_t            next_ph;

	assign first_ph = load_phase(item.pattern, 2'd0, cfg);
	assign next_ph  = load_phase(pattern_q, index_q[1:0], cfg);

	always_comb begin
		active_d  = active_q;
		pattern_d = pattern_q;
		total_d   = total_q;
		index_d   = index_q;
		ticks_d   = ticks_q;
		level_d   = level_q;
		case (item.func)
			FUNC_START: begin
				active_d  = 1'b1;
				pattern_d = item.pattern;
				// four phases per fast repetition, two per slow one
				total_d   = (item.pattern == PATTERN_FAST) ?
					{item.repeat_count, 2'b00} : {1'b0, item.repeat_count, 1'b0};
				level_d   = first_ph.level;
				ticks_d   = first_ph.ticks;
				index_d   = TICK_W'(1);
			end
			FUNC_STOP: begin
				active_d = 1'b0;
				total_d  = '0;
				index_d  = '0;
				ticks_d  = '0;
				level_d  = 1'b0;
			end
			FUNC_TICK: begin
				if (active_q) begin
					if (ticks_q > TICK_W'(1)) begin
						ticks_d = ticks_q - TICK_W'(1);
					end else if (index_q >= total_q) begin
						active_d = 1'b0;
						total_d  = '0;
						index_d  = '0;
						ticks_d  = '0;
						level_d  = 1'b0;
					end else begin
						level_d = next_ph.level;
						ticks_d = next_ph.ticks;
						index_d = index_q + TICK_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pattern_q <= PATTERN_FAST;
			total_q   <= '0;
			index_q   <= '0;
			ticks_q   <= '0;
			level_q   <= 1'b0;
		end else if (fire) begin
			active_q  <= active_d;
			pattern_q <= pattern_d;
			total_q   <= total_d;
			index_q   <= index_d;
			ticks_q   <= ticks_d;
			level_q   <= level_d;
		end
	end

	assign result.motor_on = level_d;
	assign result.busy_res = active_d;

endmodule

// File: hw/rtl/vibration_pattern_sequencer.sv
`timescale 1ns / 1ps
// Vibration pattern sequencer.
// Input stream s_*: one item per command. s_tuser carries func (tick, start, stop);
// s_tdata carries pattern and repeat_count, used only by start. Every item yields
// exactly one result item on m_*: the motor drive level and the busy flag after it.
// Durations of the fast and slow phases come from five 16-bit registers written
// through cfg_wr_en / cfg_index / cfg_data; write them only while no item is in
// flight. A change during a running sequence affects only phases loaded later.
// An accepted item passes through the input register and then the result register
// before it shows on m_*. Throughput is one item per cycle while the receiver does not
// stall: the phase counter update is a single decrement/compare/table lookup between
// the input register and the result register.
// Reset (arst_n low) clears both stages, puts the motor off, the sequence idle and
// the registers at their default durations.
// When the receiver stalls, the result stays in the output register, one more item
// waits in the input register, and s_tready drops only once both are full.
module vibration_pattern_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // [0] pattern, [14:1] repeat_count
	input  logic [1:0]                    s_tuser,  // [1:0] func
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // [0] motor_on, [1] busy_res
	// register writes
	input  logic                          cfg_wr_en,
	input  logic [vps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vps_pkg::TICK_W-1:0]    cfg_data
);
	import vps_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t res_next;
	result_t res_q;
	logic    m_valid_q;

	vps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// the item in the input register moves on when the output register is free
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func         <= s_tuser;
			item_s1.pattern      <= s_tdata[0];
			item_s1.repeat_count <= s_tdata[REPS_W:1];
		end
	end

	vps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_q.busy_res, res_q.motor_on};

endmodule

// File: hw/rtl/vps_checker.sv
`timescale 1ns / 1ps
`include "vibration_pattern_sequencer_defines.svh"
module vps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	// the motor never runs while the sequence is reported idle
	`VPS_ASSERT_IMPLY(a_motor_needs_busy, clk, arst_n, m_tvalid, !(m_tdata[0] && !m_tdata[1]))
	// with the output side empty the block always has room for an item
	`VPS_ASSERT_IMPLY(a_ready_when_drained, clk, arst_n, !m_tvalid, s_tready)
	// a stalled result holds its value
	`VPS_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// nothing leaves right after reset
	`VPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !arst_n, !m_tvalid)
endmodule

bind vibration_pattern_sequencer vps_checker u_vps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import vps_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
	localparam logic              PATTERN_SLOW = ~PATTERN_FAST;
	localparam int                HOLD_CYCLES  = 40;
	localparam int                CYCLE_LIMIT  = 200000;
	localparam int                RAND_BLOCKS  = 15;
	localparam int                BLOCK_ITEMS  = 50;

	// One line of the directed table: either a register write or an input item.
	// Rows with typed set carry their result written out by hand.
	typedef struct packed {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [TICK_W-1:0]    reg_val;
		logic [FUNC_W-1:0]    func;
		logic                 pattern;
		logic [REPS_W-1:0]    reps;
		bit                   typed;
		result_t              want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;  // [0] pattern, [14:1] repeat_count
	logic [1:0]           s_tuser;  // [1:0] func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;  // [0] motor_on, [1] busy_res
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	vibration_pattern_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow copy of the sequencer: durations plus the phase machine
	cfg_t        dur_cfg;
	bit          seq_active;
	bit          seq_pattern;
	bit [15:0]   phases_total;
	bit [15:0]   phase_num;
	bit [15:0]   ticks_remaining;
	bit          motor_level;

	result_t     motor_q[$];     // motor/busy levels still to come out
	int          err_cnt = 0;
	int          cycle_cnt = 0;
	bit          idle_en = 1'b1;
	bit          long_hold_req = 1'b0;
	bit          in_taken = 1'b0;
	bit          cur_typed = 1'b0;
	result_t     cur_want = '0;
	stim_row_t   directed[$];

	// Level and duration of phase idx of the pattern that is running
	function automatic void enter_phase(input bit [15:0] idx);
		if (seq_pattern == PATTERN_FAST) begin
			case (idx[1:0])
				2'd0: begin motor_level = 1'b1; ticks_remaining = dur_cfg.fast_on; end
				2'd1: begin motor_level = 1'b0; ticks_remaining = dur_cfg.fast_short_gap; end
				2'd2: begin motor_level = 1'b1; ticks_remaining = dur_cfg.fast_on; end
				default: begin motor_level = 1'b0; ticks_remaining = dur_cfg.fast_long_gap; end
			endcase
		end else if (idx[0] == 1'b0) begin
			motor_level = 1'b1;
			ticks_remaining = dur_cfg.slow_on;
		end else begin
			motor_level = 1'b0;
			ticks_remaining = dur_cfg.slow_gap;
		end
	endfunction

	function automatic void stop_sequence();
		seq_active = 1'b0;
		phases_total = '0;
		phase_num = '0;
		ticks_remaining = '0;
		motor_level = 1'b0;
	endfunction

	// Advance the shadow sequencer by one item, return the levels after it
	function automatic result_t sequence_step(input logic [FUNC_W-1:0] f, input logic p,
			input logic [REPS_W-1:0] r);
		result_t res;
		case (f)
			FUNC_START: begin
				seq_active = 1'b1;
				seq_pattern = p;
				phases_total = (p == PATTERN_FAST) ? {r, 2'b00} : {1'b0, r, 1'b0};
				enter_phase(16'd0);
				phase_num = 16'd1;
			end
			FUNC_STOP: stop_sequence();
			FUNC_TICK: begin
				if (seq_active) begin
					if (ticks_remaining > 16'd1) begin
						ticks_remaining = ticks_remaining - 16'd1;
					end else if (phase_num >= phases_total) begin
						stop_sequence();
					end else begin
						enter_phase(phase_num);
						phase_num = phase_num + 16'd1;
					end
				end
			end
			default: ;  // unused code: no change
		endcase
		res.motor_on = motor_level;
		res.busy_res = seq_active;
		return res;
	endfunction

	function automatic stim_row_t cmd(input logic [FUNC_W-1:0] f, input logic p,
			input logic [REPS_W-1:0] r);
		stim_row_t row;
		row = '0;
		row.func = f;
		row.pattern = p;
		row.reps = r;
		return row;
	endfunction

	function automatic stim_row_t cmd_exp(input logic [FUNC_W-1:0] f, input logic p,
			input logic [REPS_W-1:0] r, input logic motor, input logic busy);
		stim_row_t row;
		row = cmd(f, p, r);
		row.typed = 1'b1;
		row.want.motor_on = motor;
		row.want.busy_res = busy;
		return row;
	endfunction

	function automatic stim_row_t reg_wr(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] val);
		stim_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Mostly short durations so sequences run to the end; now and then huge ones
	function automatic logic [TICK_W-1:0] rand_duration();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return 16'hFFFF;
		if (k == 1)
			return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(1, 5));
	endfunction

	// Drive one register write; the caller lowers cfg_wr_en after the batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_FAST_ON:        dur_cfg.fast_on = val;
			CFG_FAST_SHORT_GAP: dur_cfg.fast_short_gap = val;
			CFG_FAST_LONG_GAP:  dur_cfg.fast_long_gap = val;
			CFG_SLOW_ON:        dur_cfg.slow_on = val;
			CFG_SLOW_GAP:       dur_cfg.slow_gap = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Stop offering items and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (motor_q.size() != 0);
	endtask

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic p,
			input logic [REPS_W-1:0] r, input bit typed, input result_t want);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tuser <= f;
		s_tdata <= {1'b0, r, p};
		s_tvalid <= 1'b1;
		cur_typed = typed;
		cur_want = want;
		do @(posedge clk); while (!in_taken);
		in_taken = 1'b0;
	endtask

	// Random item: mostly ticks driving sequences started with small repeat counts
	task automatic send_random_item();
		int unsigned k;
		logic [FUNC_W-1:0] f;
		logic p;
		logic [REPS_W-1:0] r;
		k = $urandom_range(0, 99);
		p = 1'($urandom_range(0, 1));
		r = 14'($urandom_range(0, 16383));
		if (k < 76) begin
			f = FUNC_TICK;
		end else if (k < 90) begin
			f = FUNC_START;
			k = $urandom_range(0, 9);
			if (k < 7)
				r = 14'($urandom_range(0, 3));
			else if (k == 7)
				r = '1;
		end else if (k < 95) begin
			f = FUNC_STOP;
		end else begin
			f = FUNC_UNUSED;
		end
		send_item(f, p, r, 1'b0, '0);
	endtask

	// Sample both handshakes at the falling edge ahead of the edge that completes them;
	// inputs are only ever changed at rising edges.
	always @(negedge clk) begin
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = sequence_step(s_tuser, s_tdata[0], s_tdata[14:1]);
				if (cur_typed)
					want = cur_want;
				motor_q.push_back(want);
				in_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[1:0];
				if (motor_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result item, got motor_on %0b busy_res %0b",
						$time, got.motor_on, got.busy_res);
				end else begin
					want = motor_q.pop_front();
					if (got.motor_on !== want.motor_on) begin
						err_cnt++;
						$display("%0t: motor_on mismatch, expected %0b got %0b",
							$time, want.motor_on, got.motor_on);
					end
					if (got.busy_res !== want.busy_res) begin
						err_cnt++;
						$display("%0t: busy_res mismatch, expected %0b got %0b",
							$time, want.busy_res, got.busy_res);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: short random stalls, one long hold on request
	initial begin
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_TICK;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_FAST_ON;
		cfg_data = '0;
		dur_cfg.fast_on = RST_FAST_ON;
		dur_cfg.fast_short_gap = RST_FAST_SHORT_GAP;
		dur_cfg.fast_long_gap = RST_FAST_LONG_GAP;
		dur_cfg.slow_on = RST_SLOW_ON;
		dur_cfg.slow_gap = RST_SLOW_GAP;
		seq_pattern = PATTERN_FAST;
		stop_sequence();

		directed = '{
			// reset durations in force
			cmd_exp(FUNC_TICK, PATTERN_SLOW, '1, 1'b0, 1'b0),   // tick while idle, junk fields
			cmd_exp(FUNC_UNUSED, PATTERN_FAST, '0, 1'b0, 1'b0),
			cmd_exp(FUNC_STOP, PATTERN_SLOW, '1, 1'b0, 1'b0),   // stop while idle
			cmd_exp(FUNC_START, PATTERN_FAST, '0, 1'b1, 1'b1),  // zero repeat count
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd(FUNC_UNUSED, PATTERN_SLOW, '1),
			cmd_exp(FUNC_START, PATTERN_SLOW, '1, 1'b1, 1'b1),  // largest repeat count
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd_exp(FUNC_START, PATTERN_FAST, 14'd1, 1'b1, 1'b1), // restart while active
			cmd_exp(FUNC_STOP, PATTERN_FAST, '0, 1'b0, 1'b0),
			// shortest durations: every phase lasts one tick
			reg_wr(CFG_FAST_ON, 16'd1),
			reg_wr(CFG_FAST_SHORT_GAP, 16'd1),
			reg_wr(CFG_FAST_LONG_GAP, 16'd1),
			reg_wr(CFG_SLOW_ON, 16'd1),
			reg_wr(CFG_SLOW_GAP, 16'd1),
			cmd_exp(FUNC_START, PATTERN_FAST, '0, 1'b1, 1'b1),
			cmd_exp(FUNC_TICK, PATTERN_FAST, '0, 1'b0, 1'b0),
			cmd_exp(FUNC_START, PATTERN_FAST, 14'd1, 1'b1, 1'b1),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd_exp(FUNC_START, PATTERN_SLOW, 14'd1, 1'b1, 1'b1),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			// zero duration behaves as one; longest gaps
			reg_wr(CFG_FAST_ON, 16'd0),
			reg_wr(CFG_SLOW_GAP, 16'hFFFF),
			reg_wr(CFG_FAST_SHORT_GAP, 16'hFFFF),
			cmd_exp(FUNC_START, PATTERN_FAST, 14'd2, 1'b1, 1'b1),
			cmd(FUNC_TICK, PATTERN_FAST, '0),
			// change while a sequence runs: the loaded gap keeps counting
			reg_wr(CFG_FAST_SHORT_GAP, 16'd2),
			cmd(FUNC_TICK, PATTERN_SLOW, '1),
			cmd(FUNC_TICK, PATTERN_FAST, '0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_write) begin
				if (i == 0 || !directed[i-1].is_write)
					drain_results();
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				cfg_wr_en <= 1'b0;
				send_item(directed[i].func, directed[i].pattern, directed[i].reps,
					directed[i].typed, directed[i].want);
			end
		end

		// Random blocks, each under a fresh set of durations written while drained.
		// Block 4 gets a long output hold; the last blocks run without idling.
		for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
			drain_results();
			if (blk >= RAND_BLOCKS - 3)
				idle_en = 1'b0;
			write_reg(CFG_FAST_ON, rand_duration());
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_FAST_SHORT_GAP, rand_duration());
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_FAST_LONG_GAP, rand_duration());
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_SLOW_ON, rand_duration());
			if ($urandom_range(0, 3) != 0)
				write_reg(CFG_SLOW_GAP, rand_duration());
			cfg_wr_en <= 1'b0;
			if (blk == 4)
				long_hold_req = 1'b1;
			repeat (BLOCK_ITEMS) send_random_item();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
